// ===== hw/rtl/ogru_pkg.sv =====
`timescale 1ns / 1ps

package ogru_pkg;

    // Field widths of the item channels
    localparam int COORD_W = 12;
    localparam int VALUE_W = 8;
    localparam int COUNT_W = 12;

    // Configuration port
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    // Commands
    localparam logic CMD_RAY  = 1'b0;
    localparam logic CMD_READ = 1'b1;

    // Register indexes (paddr[3:2])
    localparam logic [1:0] REG_FREE_STEP     = 2'd0;
    localparam logic [1:0] REG_OCCUPIED_STEP = 2'd1;
    localparam logic [1:0] REG_VALUE_FLOOR   = 2'd2;
    localparam logic [1:0] REG_VALUE_CEILING = 2'd3;

    // Reset values
    localparam logic [7:0] FREE_STEP_RST     = 8'hFF;
    localparam logic [6:0] OCCUPIED_STEP_RST = 7'd2;
    localparam logic [7:0] VALUE_FLOOR_RST   = 8'd0;
    localparam logic [7:0] VALUE_CEILING_RST = 8'd100;
    localparam logic [7:0] CELL_RESET        = 8'd50;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

endpackage

// ===== hw/rtl/ogru_in_if.sv =====
`timescale 1ns / 1ps

// Ray / read command channel
interface ogru_in_if;
    logic                                      valid;
    logic                                      ready;
    logic                                      command;
    logic signed [ogru_pkg::COORD_W-1:0]       robot_x;
    logic signed [ogru_pkg::COORD_W-1:0]       robot_y;
    logic signed [ogru_pkg::COORD_W-1:0]       hit_x;
    logic signed [ogru_pkg::COORD_W-1:0]       hit_y;

    modport source (output valid, command, robot_x, robot_y, hit_x, hit_y, input ready);
    modport sink   (input valid, command, robot_x, robot_y, hit_x, hit_y, output ready);
endinterface

// ===== hw/rtl/ogru_out_if.sv =====
`timescale 1ns / 1ps

// Result channel
interface ogru_out_if;
    logic                              valid;
    logic                              ready;
    logic [ogru_pkg::VALUE_W-1:0]      cell_value;
    logic                              ray_accepted;
    logic [ogru_pkg::COUNT_W-1:0]      cells_freed;

    modport source (output valid, cell_value, ray_accepted, cells_freed, input ready);
    modport sink   (input valid, cell_value, ray_accepted, cells_freed, output ready);
endinterface

// ===== hw/rtl/occupancy_grid_ray_update.sv =====
`timescale 1ns / 1ps

// Occupancy grid ray update. Holds a GRID_SIDE x GRID_SIDE map of 8-bit cells in a
// single-port-per-direction memory (one write, one registered read per cycle).
// After reset the block sweeps the map to 50, one cell per cycle, and takes no
// item meanwhile; configuration writes are taken at any time. One item is
// handled at a time and each gives exactly one result. A read looks up the hit
// cell and returns its value; a ray or read whose hit lies outside the grid goes
// straight to the result. A ray update runs the Bresenham walker, which visits
// one line cell per cycle, overlapping the read of one cell with the write-back
// of the previous one, then reads and writes the hit cell. The major axis is the
// one with the larger of |dx| and |dy|.
// Configuration is written through an APB port, register i at byte address 4*i.
module occupancy_grid_ray_update #(
    parameter int GRID_SIDE = 256
) (
    input  logic                              clk,
    input  logic                              rst_n,
    ogru_in_if.sink                           in_item,
    ogru_out_if.source                        out_item,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [ogru_pkg::PADDR_W-1:0]      paddr,
    input  logic [ogru_pkg::PDATA_W-1:0]      pwdata,
    output logic [ogru_pkg::PDATA_W-1:0]      prdata,
    output logic                              pready
);

    localparam int CW     = ogru_pkg::COORD_W;
    localparam int IDX_W  = $clog2(GRID_SIDE);
    localparam int CELLS  = GRID_SIDE * GRID_SIDE;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int ERR_W  = CW + 3;

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_SETUP  = 3'd2;
    localparam logic [2:0] S_ORIENT = 3'd3;
    localparam logic [2:0] S_WALK   = 3'd4;
    localparam logic [2:0] S_HIT_RD = 3'd5;
    localparam logic [2:0] S_FINISH = 3'd6;

    function automatic logic in_grid(input logic signed [CW-1:0] x,
                                     input logic signed [CW-1:0] y);
        return !x[CW-1] && ($unsigned(x) < CW'(GRID_SIDE))
            && !y[CW-1] && ($unsigned(y) < CW'(GRID_SIDE));
    endfunction

    function automatic logic [ADDR_W-1:0] cell_addr(input logic signed [CW-1:0] x,
                                                    input logic signed [CW-1:0] y);
        return ADDR_W'(x[IDX_W-1:0]) * ADDR_W'(GRID_SIDE) + ADDR_W'(y[IDX_W-1:0]);
    endfunction

    function automatic logic [CW-1:0] abs_diff(input logic signed [CW-1:0] p,
                                               input logic signed [CW-1:0] q);
        logic signed [CW:0] d;
        d = {p[CW-1], p} - {q[CW-1], q};
        return d[CW] ? CW'(-d) : d[CW-1:0];
    endfunction

    // Configuration registers
    logic [7:0] free_step_reg;
    logic [6:0] occupied_step_reg;
    logic [7:0] value_floor_reg;
    logic [7:0] value_ceiling_reg;
    logic [1:0] cfg_index;
    logic       cfg_write;

    // Sequencer and walker state
    logic [2:0]              state_reg, state_next;
    logic [ADDR_W-1:0]       clr_addr_reg, clr_addr_next;
    logic                    cmd_reg;
    logic signed [CW-1:0]    rx_reg, ry_reg, hx_reg, hy_reg;
    logic                    steep_reg, steep_next;
    logic                    hit_in_reg, hit_in_next;
    logic [ADDR_W-1:0]       hit_addr_reg, hit_addr_next;
    logic signed [CW-1:0]    a_reg, a_next;
    logic signed [CW-1:0]    a_end_reg, a_end_next;
    logic signed [CW-1:0]    b_reg, b_next;
    logic signed [ERR_W-1:0] err_reg, err_next;
    logic [CW-1:0]           da_reg, da_next;
    logic [CW-1:0]           db_reg, db_next;
    logic                    b_down_reg, b_down_next;
    logic [ogru_pkg::COUNT_W-1:0] freed_reg, freed_next;

    // Free write-back pipeline
    logic                    fw_pend_reg, fw_pend_next;
    logic [ADDR_W-1:0]       fw_addr_reg, fw_addr_next;

    // Map memory
    logic [7:0]              map_mem [CELLS];
    logic [7:0]              rd_data_reg;
    logic                    mem_re, mem_we;
    logic [ADDR_W-1:0]       mem_raddr, mem_waddr;
    logic [7:0]              mem_wdata;

    // Result register
    logic                    out_valid_reg, out_valid_next;
    logic [7:0]              out_value_reg, out_value_next;
    logic                    out_acc_reg, out_acc_next;
    logic [ogru_pkg::COUNT_W-1:0] out_freed_reg, out_freed_next;
    logic                    out_free;

    // Datapath values
    logic signed [CW-1:0]    px, py, a0, a1, b0, b1, sa0, sa1, sb0, sb1;
    logic signed [CW:0]      a_span;
    logic signed [ERR_W-1:0] err_sum;
    logic signed [ERR_W:0]   err_twice;
    logic                    cell_ok;
    logic [ADDR_W-1:0]       walk_addr;
    logic signed [9:0]       free_sum;
    logic [7:0]              free_val;
    logic [8:0]              hit_sum;
    logic [7:0]              hit_val;
    logic                    hit_write;

    // APB port
    assign pready    = 1'b1;
    assign cfg_index = paddr[3:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        unique case (cfg_index)
            ogru_pkg::REG_FREE_STEP:     prdata = {{24{free_step_reg[7]}}, free_step_reg};
            ogru_pkg::REG_OCCUPIED_STEP: prdata = {25'd0, occupied_step_reg};
            ogru_pkg::REG_VALUE_FLOOR:   prdata = {24'd0, value_floor_reg};
            ogru_pkg::REG_VALUE_CEILING: prdata = {24'd0, value_ceiling_reg};
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_step_reg     <= ogru_pkg::FREE_STEP_RST;
            occupied_step_reg <= ogru_pkg::OCCUPIED_STEP_RST;
            value_floor_reg   <= ogru_pkg::VALUE_FLOOR_RST;
            value_ceiling_reg <= ogru_pkg::VALUE_CEILING_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                ogru_pkg::REG_FREE_STEP:     free_step_reg     <= pwdata[7:0];
                ogru_pkg::REG_OCCUPIED_STEP: occupied_step_reg <= pwdata[6:0];
                ogru_pkg::REG_VALUE_FLOOR:   value_floor_reg   <= pwdata[7:0];
                ogru_pkg::REG_VALUE_CEILING: value_ceiling_reg <= pwdata[7:0];
            endcase
        end
    end

    // Handshakes
    assign in_item.ready = (state_reg == S_IDLE);
    assign out_free      = !out_valid_reg || out_item.ready;

    assign out_item.valid        = out_valid_reg;
    assign out_item.cell_value   = out_value_reg;
    assign out_item.ray_accepted = out_acc_reg;
    assign out_item.cells_freed  = out_freed_reg;

    // Orientation: major axis a, minor axis b, walked from low a to high a
    assign a0     = steep_reg ? ry_reg : rx_reg;
    assign b0     = steep_reg ? rx_reg : ry_reg;
    assign a1     = steep_reg ? hy_reg : hx_reg;
    assign b1     = steep_reg ? hx_reg : hy_reg;
    assign sa0    = (a0 > a1) ? a1 : a0;
    assign sa1    = (a0 > a1) ? a0 : a1;
    assign sb0    = (a0 > a1) ? b1 : b0;
    assign sb1    = (a0 > a1) ? b0 : b1;
    assign a_span = {sa1[CW-1], sa1} - {sa0[CW-1], sa0};

    // Walker step
    assign px        = steep_reg ? b_reg : a_reg;
    assign py        = steep_reg ? a_reg : b_reg;
    assign err_sum   = err_reg + ERR_W'(db_reg);
    assign err_twice = {err_sum, 1'b0};
    assign cell_ok   = in_grid(px, py) && !(px == hx_reg && py == hy_reg);
    assign walk_addr = cell_addr(px, py);

    // Free update of the cell read in the previous cycle
    assign free_sum = $signed({2'b00, rd_data_reg}) + 10'(signed'(free_step_reg));
    always_comb
    begin
        if (free_sum < $signed({2'b00, value_floor_reg}))
            free_val = value_floor_reg;
        else if (free_sum > 10'sd255)
            free_val = 8'hFF;
        else
            free_val = free_sum[7:0];
    end

    // Hit update
    assign hit_sum = {1'b0, rd_data_reg} + {2'b00, occupied_step_reg};
    assign hit_val = (hit_sum > {1'b0, value_ceiling_reg}) ? value_ceiling_reg : hit_sum[7:0];
    assign hit_write = (state_reg == S_FINISH) && out_free && hit_in_reg
                       && (cmd_reg == ogru_pkg::CMD_RAY);

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        clr_addr_next  = clr_addr_reg;
        steep_next     = steep_reg;
        hit_in_next    = hit_in_reg;
        hit_addr_next  = hit_addr_reg;
        a_next         = a_reg;
        a_end_next     = a_end_reg;
        b_next         = b_reg;
        err_next       = err_reg;
        da_next        = da_reg;
        db_next        = db_reg;
        b_down_next    = b_down_reg;
        freed_next     = freed_reg;
        fw_pend_next   = 1'b0;
        fw_addr_next   = fw_addr_reg;
        mem_re         = 1'b0;
        mem_raddr      = hit_addr_reg;
        out_valid_next = out_valid_reg && !out_item.ready;
        out_value_next = out_value_reg;
        out_acc_next   = out_acc_reg;
        out_freed_next = out_freed_reg;

        unique case (state_reg)
            S_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == ADDR_W'(CELLS - 1))
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_item.valid)
                    state_next = S_SETUP;
            end
            S_SETUP:
            begin
                steep_next    = abs_diff(hy_reg, ry_reg) > abs_diff(hx_reg, rx_reg);
                hit_in_next   = in_grid(hx_reg, hy_reg);
                hit_addr_next = cell_addr(hx_reg, hy_reg);
                if (!in_grid(hx_reg, hy_reg))
                    state_next = S_FINISH;
                else if (cmd_reg == ogru_pkg::CMD_READ)
                    state_next = S_HIT_RD;
                else
                    state_next = S_ORIENT;
            end
            S_ORIENT:
            begin
                a_next      = sa0;
                a_end_next  = sa1;
                b_next      = sb0;
                err_next    = '0;
                da_next     = a_span[CW-1:0];
                db_next     = abs_diff(sb1, sb0);
                b_down_next = !(sb0 < sb1);
                freed_next  = '0;
                state_next  = S_WALK;
            end
            S_WALK:
            begin
                // Visit the current cell, then advance along the line
                if (cell_ok)
                begin
                    mem_re       = 1'b1;
                    mem_raddr    = walk_addr;
                    fw_pend_next = 1'b1;
                    fw_addr_next = walk_addr;
                    if (freed_reg != ogru_pkg::COUNT_MAX)
                        freed_next = freed_reg + 1'b1;
                end
                if (err_twice >= $signed({{(ERR_W - CW + 1){1'b0}}, da_reg}))
                begin
                    b_next   = b_down_reg ? b_reg - 1'b1 : b_reg + 1'b1;
                    err_next = err_sum - ERR_W'(da_reg);
                end
                else
                    err_next = err_sum;
                if (a_reg == a_end_reg)
                    state_next = S_HIT_RD;
                else
                    a_next = a_reg + 1'b1;
            end
            S_HIT_RD:
            begin
                mem_re     = 1'b1;
                mem_raddr  = hit_addr_reg;
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_acc_next   = hit_in_reg;
                    if (!hit_in_reg)
                    begin
                        out_value_next = '0;
                        out_freed_next = '0;
                    end
                    else if (cmd_reg == ogru_pkg::CMD_READ)
                    begin
                        out_value_next = rd_data_reg;
                        out_freed_next = '0;
                    end
                    else
                    begin
                        out_value_next = hit_val;
                        out_freed_next = freed_reg;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Memory write port: clearing pass, free write-back, hit write
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = fw_addr_reg;
        mem_wdata = free_val;
        if (state_reg == S_CLEAR)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_addr_reg;
            mem_wdata = ogru_pkg::CELL_RESET;
        end
        else if (fw_pend_reg)
            mem_we = 1'b1;
        else if (hit_write)
        begin
            mem_we    = 1'b1;
            mem_waddr = hit_addr_reg;
            mem_wdata = hit_val;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            map_mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            rd_data_reg <= map_mem[mem_raddr];
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_addr_reg  <= '0;
            fw_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            fw_pend_reg   <= fw_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_item.valid && in_item.ready)
        begin
            cmd_reg <= in_item.command;
            rx_reg  <= in_item.robot_x;
            ry_reg  <= in_item.robot_y;
            hx_reg  <= in_item.hit_x;
            hy_reg  <= in_item.hit_y;
        end
        steep_reg     <= steep_next;
        hit_in_reg    <= hit_in_next;
        hit_addr_reg  <= hit_addr_next;
        a_reg         <= a_next;
        a_end_reg     <= a_end_next;
        b_reg         <= b_next;
        err_reg       <= err_next;
        da_reg        <= da_next;
        db_reg        <= db_next;
        b_down_reg    <= b_down_next;
        freed_reg     <= freed_next;
        fw_addr_reg   <= fw_addr_next;
        out_value_reg <= out_value_next;
        out_acc_reg   <= out_acc_next;
        out_freed_reg <= out_freed_next;
    end

endmodule
